FILE: design/bgd_pkg.sv
`default_nettype none

package bgd_pkg;

  localparam int TICK_COUNTER_BITS_DEF = 16;

  // result queue holds two full ticks so a tick can enter while one waits
  localparam int RESQ_DEPTH = 4;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_PRESS     = 5'b00010,
    ST_RELEASE   = 5'b00100,
    ST_REPEAT    = 5'b01000,
    ST_LONG_HOLD = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    EV_DOWN       = 3'd0,
    EV_UP         = 3'd1,
    EV_REPEAT     = 3'd2,
    EV_SINGLE     = 3'd3,
    EV_DOUBLE     = 3'd4,
    EV_LONG_START = 3'd5,
    EV_LONG_HOLD  = 3'd6,
    EV_NONE       = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    REG_PRESS_POLARITY = 3'd0,
    REG_SETTLE_TICKS   = 3'd1,
    REG_CLICK_WINDOW   = 3'd2,
    REG_HOLD_THRESHOLD = 3'd3,
    REG_REPEAT_LIMIT   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic        press_polarity;
    logic [2:0]  settle_ticks;
    logic [15:0] click_window;
    logic [15:0] hold_threshold;
    logic [3:0]  repeat_limit;
  } cfg_t;

  typedef struct packed {
    event_t     event_code;
    logic [3:0] repeat_count;
    logic       last_of_tick;
  } result_t;

  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } step_out_t;

endpackage

`default_nettype wire

FILE: design/bgd_step.sv
`default_nettype none

module bgd_step #(
  parameter int TICK_COUNTER_BITS = bgd_pkg::TICK_COUNTER_BITS_DEF
) (
  input  bgd_pkg::cfg_t                cfg,
  input  bgd_pkg::state_t              state,
  input  logic [TICK_COUNTER_BITS-1:0] tick_count,
  input  logic [2:0]                   debounce_count,
  input  logic                         held_level,
  input  logic [3:0]                   press_repeats,
  input  logic                         raw_level,
  output bgd_pkg::state_t              state_next,
  output logic [TICK_COUNTER_BITS-1:0] tick_count_next,
  output logic [2:0]                   debounce_count_next,
  output logic                         held_level_next,
  output logic [3:0]                   press_repeats_next,
  output bgd_pkg::step_out_t           step_out
);
  import bgd_pkg::*;

  localparam int CW = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;

  logic [TICK_COUNTER_BITS-1:0] tick_inc;
  logic [CW-1:0]                tick_ext;
  logic [CW-1:0]                short_ext;
  logic [CW-1:0]                long_ext;
  logic [2:0]                   dc_inc;
  logic                         pressed;
  event_t                       ev0;
  event_t                       ev1;
  logic                         has_ev;
  logic                         two;

  always_comb begin
    tick_inc = tick_count;
    if (state != ST_IDLE && !(&tick_count)) begin
      tick_inc = tick_count + TICK_COUNTER_BITS'(1);
    end
    tick_ext  = CW'(tick_inc);
    short_ext = CW'(cfg.click_window);
    long_ext  = CW'(cfg.hold_threshold);

    // debounce: new level must persist for settle_ticks ticks
    dc_inc = debounce_count + 3'd1;
    held_level_next = held_level;
    if (raw_level != held_level) begin
      if (dc_inc >= cfg.settle_ticks) begin
        held_level_next     = raw_level;
        debounce_count_next = 3'd0;
      end else begin
        debounce_count_next = dc_inc;
      end
    end else begin
      debounce_count_next = 3'd0;
    end
    pressed = (held_level_next == cfg.press_polarity);

    state_next         = state;
    tick_count_next    = tick_inc;
    press_repeats_next = press_repeats;
    ev0    = EV_NONE;
    ev1    = EV_NONE;
    has_ev = 1'b0;
    two    = 1'b0;

    case (state)
      ST_IDLE: begin
        if (pressed) begin
          ev0 = EV_DOWN;
          has_ev = 1'b1;
          tick_count_next = '0;
          press_repeats_next = 4'd1;
          state_next = ST_PRESS;
        end
      end
      ST_PRESS: begin
        if (!pressed) begin
          ev0 = EV_UP;
          has_ev = 1'b1;
          tick_count_next = '0;
          state_next = ST_RELEASE;
        end else if (tick_ext > long_ext) begin
          ev0 = EV_LONG_START;
          has_ev = 1'b1;
          state_next = ST_LONG_HOLD;
        end
      end
      ST_RELEASE: begin
        if (pressed) begin
          // re-press gives down then repeat
          ev0 = EV_DOWN;
          ev1 = EV_REPEAT;
          has_ev = 1'b1;
          two = 1'b1;
          if (press_repeats < cfg.repeat_limit) begin
            press_repeats_next = press_repeats + 4'd1;
          end
          tick_count_next = '0;
          state_next = ST_REPEAT;
        end else if (tick_ext > short_ext) begin
          if (press_repeats == 4'd1) begin
            ev0 = EV_SINGLE;
            has_ev = 1'b1;
          end else if (press_repeats == 4'd2) begin
            ev0 = EV_DOUBLE;
            has_ev = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_REPEAT: begin
        if (!pressed) begin
          ev0 = EV_UP;
          has_ev = 1'b1;
          if (tick_ext < short_ext) begin
            tick_count_next = '0;
            state_next = ST_RELEASE;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (tick_ext > short_ext) begin
          tick_count_next = '0;
          press_repeats_next = 4'd0;
          state_next = ST_PRESS;
        end
      end
      ST_LONG_HOLD: begin
        has_ev = 1'b1;
        if (pressed) begin
          ev0 = EV_LONG_HOLD;
        end else begin
          ev0 = EV_UP;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (!has_ev) begin
      ev0 = EV_NONE;
    end

    step_out.first.event_code    = ev0;
    step_out.first.repeat_count  = press_repeats_next;
    step_out.first.last_of_tick  = !two;
    step_out.second.event_code   = ev1;
    step_out.second.repeat_count = press_repeats_next;
    step_out.second.last_of_tick = 1'b1;
    step_out.two                 = two;
  end

endmodule

`default_nettype wire

FILE: design/bgd_resq.sv
`default_nettype none

module bgd_resq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bgd_pkg::step_out_t step_out,
  output logic               out_valid,
  input  logic               out_ready,
  output bgd_pkg::result_t   head,
  output logic               space_two
);
  import bgd_pkg::*;

  localparam int AW   = $clog2(RESQ_DEPTH);
  localparam int CNTW = $clog2(RESQ_DEPTH + 1);

  result_t         mem [RESQ_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] fill;
  logic [CNTW-1:0] fill_next;
  logic            pop;
  logic [AW-1:0]   wr_ptr_inc;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (fill != '0);
  assign head       = mem[rd_ptr];
  assign space_two  = (fill <= CNTW'(RESQ_DEPTH - 2));
  assign wr_ptr_inc = wr_ptr + AW'(1);

  always_comb begin
    fill_next = fill;
    if (push) begin
      fill_next = step_out.two ? fill + CNTW'(2) : fill + CNTW'(1);
    end
    if (pop) begin
      fill_next = fill_next - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= step_out.first;
      if (step_out.two) begin
        mem[wr_ptr_inc] <= step_out.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= step_out.two ? wr_ptr + AW'(2) : wr_ptr_inc;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/button_gesture_detector_core.sv
`default_nettype none

// channel   direction  handshake               payload
// cfg       in         cfg_valid / cfg_ready   cfg_index[2:0], cfg_data[15:0]
// in        in         in_valid / in_ready     raw_level
// out       out        out_valid / out_ready   event_code, repeat_count, last_of_tick
//
// a tick is worked in the cycle of its transfer; its one or two results are
// in the result queue at the next edge.
// one tick per cycle is taken while the four-entry result queue has room
// for two results; a re-press tick emits two results and takes two slots.
// out_ready low stalls the queue, and in_ready drops once fewer than two slots are free.
// rst clears the state, the queue and the registers to their defaults.
// cfg_ready is always high; a write to an unknown index is dropped.

module button_gesture_detector_core #(
  parameter int TICK_COUNTER_BITS = bgd_pkg::TICK_COUNTER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        raw_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_code,
  output logic [3:0]  repeat_count,
  output logic        last_of_tick
);
  import bgd_pkg::*;

  cfg_t                         cfg;
  state_t                       state;
  state_t                       state_next;
  logic [TICK_COUNTER_BITS-1:0] tick_count;
  logic [TICK_COUNTER_BITS-1:0] tick_count_next;
  logic [2:0]                   debounce_count;
  logic [2:0]                   debounce_count_next;
  logic                         held_level;
  logic                         held_level_next;
  logic [3:0]                   press_repeats;
  logic [3:0]                   press_repeats_next;
  step_out_t                    step_out;
  result_t                      head;
  logic                         space_two;
  logic                         in_fire;

  assign cfg_ready    = 1'b1;
  assign in_ready     = space_two;
  assign in_fire      = in_valid && in_ready;
  assign event_code   = head.event_code;
  assign repeat_count = head.repeat_count;
  assign last_of_tick = head.last_of_tick;

  bgd_step #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_step (
    .cfg                 (cfg),
    .state               (state),
    .tick_count          (tick_count),
    .debounce_count      (debounce_count),
    .held_level          (held_level),
    .press_repeats       (press_repeats),
    .raw_level           (raw_level),
    .state_next          (state_next),
    .tick_count_next     (tick_count_next),
    .debounce_count_next (debounce_count_next),
    .held_level_next     (held_level_next),
    .press_repeats_next  (press_repeats_next),
    .step_out            (step_out)
  );

  bgd_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .step_out  (step_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .space_two (space_two)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_polarity <= 1'b0;
      cfg.settle_ticks   <= 3'd2;
      cfg.click_window   <= 16'd60;
      cfg.hold_threshold <= 16'd400;
      cfg.repeat_limit   <= 4'd15;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESS_POLARITY: cfg.press_polarity <= cfg_data[0];
        REG_SETTLE_TICKS:   cfg.settle_ticks   <= cfg_data[2:0];
        REG_CLICK_WINDOW:   cfg.click_window   <= cfg_data;
        REG_HOLD_THRESHOLD: cfg.hold_threshold <= cfg_data;
        REG_REPEAT_LIMIT:   cfg.repeat_limit   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tick_count     <= '0;
      debounce_count <= 3'd0;
      held_level     <= 1'b1;
      press_repeats  <= 4'd0;
    end else if (in_fire) begin
      state          <= state_next;
      tick_count     <= tick_count_next;
      debounce_count <= debounce_count_next;
      held_level     <= held_level_next;
      press_repeats  <= press_repeats_next;
    end
  end

  // state only moves on a tick transfer
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(state) && $stable(held_level) && $stable(press_repeats))
    else $error("tick state changed without a tick transfer");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted tick left no result");

  // the second result of a tick is queued together with the first
  a_pair_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_tick |=> out_valid && last_of_tick)
    else $error("first of two results not followed by its last");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bgd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_TICKS = 68;
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST = 3'd7;

  typedef enum logic {ROW_TICKS, ROW_WRITE} row_kind_t;

  // tick rows: level held for value ticks, optional check of the model's last predicted result
  // write rows: register index and data; index is ignored on tick rows
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  index;
    logic [15:0] value;
    logic        level;
    logic        typed;
    event_t      ev;
    logic [3:0]  count;
  } script_row_t;

  localparam int NUM_ROWS = 32;
  localparam script_row_t SCRIPT [NUM_ROWS] = '{
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b1, 1'b1, EV_NONE, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b0, 1'b1, EV_NONE, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b0, 1'b1, EV_DOWN, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd2, 1'b1, 1'b1, EV_UP, 4'd1},
    '{ROW_WRITE, REG_CLICK_WINDOW, 16'd2, 1'b0, 1'b0, EV_NONE, 4'd0},
    '{ROW_WRITE, REG_SETTLE_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 4'd0},
    '{ROW_WRITE, REG_HOLD_THRESHOLD, 16'd1, 1'b0, 1'b0, EV_NONE, 4'd0},
    '{ROW_WRITE, REG_SPARE_FIRST, 16'hffff, 1'b0, 1'b0, EV_NONE, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd3, 1'b1, 1'b1, EV_SINGLE, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b0, 1'b1, EV_DOWN, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b1, 1'b1, EV_UP, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b0, 1'b1, EV_REPEAT, 4'd2},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b1, 1'b1, EV_UP, 4'd2},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd3, 1'b1, 1'b1, EV_DOUBLE, 4'd2},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd3, 1'b0, 1'b1, EV_LONG_START, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b0, 1'b1, EV_LONG_HOLD, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b1, 1'b1, EV_UP, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b0, 1'b0, EV_NONE, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b1, 1'b0, EV_NONE, 4'd0},
    // re-press held past the click window drops back to pressed silently
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd4, 1'b0, 1'b1, EV_NONE, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b1, 1'b1, EV_UP, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd3, 1'b1, 1'b1, EV_NONE, 4'd0},
    '{ROW_WRITE, REG_REPEAT_LIMIT, 16'd0, 1'b0, 1'b0, EV_NONE, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b0, 1'b0, EV_NONE, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b1, 1'b0, EV_NONE, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b0, 1'b1, EV_REPEAT, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b1, 1'b1, EV_UP, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd3, 1'b1, 1'b1, EV_SINGLE, 4'd1},
    '{ROW_WRITE, REG_PRESS_POLARITY, 16'd1, 1'b0, 1'b0, EV_NONE, 4'd0},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b1, 1'b1, EV_DOWN, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd1, 1'b0, 1'b1, EV_UP, 4'd1},
    '{ROW_TICKS, REG_SPARE_FIRST, 16'd3, 1'b0, 1'b1, EV_SINGLE, 4'd1}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        raw_level = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_code;
  logic [3:0]  repeat_count;
  logic        last_of_tick;

  // gesture tracker shadow, same reset values as the block
  cfg_t shadow_cfg = '{press_polarity: 1'b0, settle_ticks: 3'd2, click_window: 16'd60,
                       hold_threshold: 16'd400, repeat_limit: 4'd15};
  state_t      gesture_mode = ST_IDLE;
  logic [15:0] hold_ticks = '0;
  logic [2:0]  bounce_run = '0;
  logic        stable_level = 1'b1;
  logic [3:0]  press_count = '0;

  result_t expected_events [$];
  result_t oldest;
  int      fail_count = 0;
  int      idle_cycles = 0;
  logic    calm = 1'b0;

  button_gesture_detector_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .raw_level    (raw_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .repeat_count (repeat_count),
    .last_of_tick (last_of_tick)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void compare_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, label, want, got);
      fail_count++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // debounce, then advance the gesture fsm; queues the events of one tick
  task automatic predict_gestures(input logic lvl, output result_t tail);
    event_t evs [$];
    logic   pressed;
    if (gesture_mode != ST_IDLE && hold_ticks != '1) hold_ticks = hold_ticks + 16'd1;
    if (lvl != stable_level) begin
      bounce_run = bounce_run + 3'd1;
      if (bounce_run >= shadow_cfg.settle_ticks) begin
        stable_level = lvl;
        bounce_run = '0;
      end
    end else begin
      bounce_run = '0;
    end
    pressed = (stable_level == shadow_cfg.press_polarity);
    case (gesture_mode)
      ST_IDLE: begin
        if (pressed) begin
          evs.push_back(EV_DOWN);
          hold_ticks = '0;
          press_count = 4'd1;
          gesture_mode = ST_PRESS;
        end
      end
      ST_PRESS: begin
        if (!pressed) begin
          evs.push_back(EV_UP);
          hold_ticks = '0;
          gesture_mode = ST_RELEASE;
        end else if (hold_ticks > shadow_cfg.hold_threshold) begin
          evs.push_back(EV_LONG_START);
          gesture_mode = ST_LONG_HOLD;
        end
      end
      ST_RELEASE: begin
        if (pressed) begin
          evs.push_back(EV_DOWN);
          if (press_count < shadow_cfg.repeat_limit) press_count = press_count + 4'd1;
          evs.push_back(EV_REPEAT);
          hold_ticks = '0;
          gesture_mode = ST_REPEAT;
        end else if (hold_ticks > shadow_cfg.click_window) begin
          if (press_count == 4'd1) evs.push_back(EV_SINGLE);
          else if (press_count == 4'd2) evs.push_back(EV_DOUBLE);
          gesture_mode = ST_IDLE;
        end
      end
      ST_REPEAT: begin
        if (!pressed) begin
          evs.push_back(EV_UP);
          if (hold_ticks < shadow_cfg.click_window) begin
            hold_ticks = '0;
            gesture_mode = ST_RELEASE;
          end else begin
            gesture_mode = ST_IDLE;
          end
        end else if (hold_ticks > shadow_cfg.click_window) begin
          hold_ticks = '0;
          press_count = '0;
          gesture_mode = ST_PRESS;
        end
      end
      ST_LONG_HOLD: begin
        if (pressed) begin
          evs.push_back(EV_LONG_HOLD);
        end else begin
          evs.push_back(EV_UP);
          gesture_mode = ST_IDLE;
        end
      end
      default: gesture_mode = ST_IDLE;
    endcase
    if (evs.size() == 0) evs.push_back(EV_NONE);
    foreach (evs[k]) begin
      tail = '{event_code: evs[k], repeat_count: press_count,
               last_of_tick: (k == evs.size() - 1)};
      expected_events.push_back(tail);
    end
  endtask

  task automatic send_tick(input logic lvl, output result_t tail);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_gestures(lvl, tail);
  endtask

  task automatic send_run(input logic lvl, input int unsigned n, output result_t tail);
    for (int unsigned k = 0; k < n; k++) send_tick(lvl, tail);
  endtask

  // only with nothing in flight: every tick yields a result, so an empty queue means idle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PRESS_POLARITY: shadow_cfg.press_polarity = data[0];
      REG_SETTLE_TICKS:   shadow_cfg.settle_ticks = data[2:0];
      REG_CLICK_WINDOW:   shadow_cfg.click_window = data;
      REG_HOLD_THRESHOLD: shadow_cfg.hold_threshold = data;
      REG_REPEAT_LIMIT:   shadow_cfg.repeat_limit = data[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry noise, sometimes a write to a spare index
  task automatic apply_settings(input logic act, input logic [2:0] deb,
                                input logic [15:0] sep, input logic [15:0] hold,
                                input logic [3:0] lim);
    write_reg(REG_PRESS_POLARITY, {15'($urandom), act});
    write_reg(REG_SETTLE_TICKS, {13'($urandom), deb});
    write_reg(REG_CLICK_WINDOW, sep);
    write_reg(REG_HOLD_THRESHOLD, hold);
    write_reg(REG_REPEAT_LIMIT, {12'($urandom), lim});
    if ($urandom_range(0, 1) == 1)
      write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom));
  endtask

  function automatic int unsigned gesture_len();
    int unsigned span;
    case ($urandom_range(0, 3))
      0: span = $urandom_range(1, 6);
      1: span = shadow_cfg.click_window + shadow_cfg.settle_ticks + $urandom_range(0, 4);
      2: span = shadow_cfg.hold_threshold + shadow_cfg.settle_ticks + $urandom_range(0, 4);
      default: span = $urandom_range(1, 12);
    endcase
    if (span > 2) span = span - 2;
    if (span > 48) span = $urandom_range(20, 48);
    return span;
  endfunction

  // mostly alternating press / release of lengths near the timing limits
  task automatic random_phase(input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    int unsigned flip_at;
    int unsigned roll;
    logic        down;
    logic        lvl;
    result_t     tail;
    sent = 0;
    down = 1'b0;
    while (sent < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        len = $urandom_range(1, 8);
        for (int unsigned k = 0; k < len; k++) send_tick(1'($urandom), tail);
      end else begin
        down = !down;
        len = gesture_len();
        // contact bounce: for some segments, one flipped tick inside the segment
        flip_at = (roll < 30) ? $urandom_range(0, len - 1) : len;
        for (int unsigned k = 0; k < len; k++) begin
          lvl = down ? shadow_cfg.press_polarity : !shadow_cfg.press_polarity;
          send_tick(lvl ^ (k == flip_at), tail);
        end
      end
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: result expected none got event_code %0d repeat_count %0d last %0d",
                   $time, event_code, repeat_count, last_of_tick);
          fail_count++;
        end else begin
          oldest = expected_events.pop_front();
          compare_field("event_code", oldest.event_code, event_code);
          compare_field("repeat_count", oldest.repeat_count, repeat_count);
          compare_field("last_of_tick", oldest.last_of_tick, last_of_tick);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned run;
    int unsigned gap;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    script_row_t row;
    result_t     tail;
    logic [15:0] sep;
    logic [15:0] hold;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = SCRIPT[r];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.index, row.value);
      end else begin
        send_run(row.level, row.value, tail);
        if (row.typed) begin
          compare_field("directed event_code", row.ev, tail.event_code);
          compare_field("directed repeat_count", row.count, tail.repeat_count);
        end
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = 1'b0;
      case (p)
        0: apply_settings(1'b1, 3'd7, 16'd0, 16'd0, 4'd1);
        1: apply_settings(1'b0, 3'd0, 16'hffff, 16'hffff, 4'd15);
        default: begin
          sep = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 65535))
                                            : 16'($urandom_range(0, 12));
          hold = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
          apply_settings(1'($urandom), 3'($urandom_range(0, 7)), sep, hold,
                         4'($urandom_range(0, 15)));
        end
      endcase
      calm = ($urandom_range(0, 3) == 0);
      random_phase(PHASE_TICKS);
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
